// ===== sv/oas_pkg.sv =====
`default_nettype none
package oas_pkg;
	localparam int MaxSize = 16;
	localparam int Dim = MaxSize + 1;
	localparam int IdxW = $clog2(Dim);
	localparam int AddrW = $clog2(MaxSize * MaxSize);
	localparam int CostW = 16;
	localparam int PotW = 32;
	localparam logic signed [PotW-1:0] Inf = 32'sh7FFFFFFF;
	localparam logic signed [PotW-1:0] Min = 32'sh80000000;

	typedef logic [IdxW-1:0] idx_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_ROW_INIT,
		CMD_VISIT,
		CMD_SCAN,
		CMD_SCAN_LAST,
		CMD_UPDATE,
		CMD_STEP,
		CMD_AUG,
		CMD_EMIT
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		idx_t j;
	} cmd_t;

	typedef struct packed {
		logic found;
		logic cur_free;
		logic cur_zero;
		idx_t emit_row;
	} sts_t;

	function automatic logic signed [PotW-1:0] sat32(input logic signed [PotW+1:0] v);
		logic signed [PotW-1:0] r;
		if (v > PotW'(Inf)) r = Inf;
		else if (v < $signed({{2{1'b1}}, Min})) r = Min;
		else r = v[PotW-1:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/oas_if.sv =====
`default_nettype none
interface oas_in_if;
	logic valid;
	logic ready;
	logic [4:0] size;
	logic [15:0] cost;
	modport source(output valid, size, cost, input ready);
	modport sink(input valid, size, cost, output ready);
endinterface

interface oas_out_if;
	logic valid;
	logic ready;
	logic [3:0] column;
	logic [3:0] row;
	logic last;
	modport source(output valid, column, row, last, input ready);
	modport sink(input valid, column, row, last, output ready);
endinterface
`default_nettype wire

// ===== sv/oas_ram.sv =====
`default_nettype none
module oas_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(Depth)-1:0] waddr,
	input wire logic [Width-1:0] wdata,
	input wire logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/oas_datapath.sv =====
`default_nettype none
module oas_datapath import oas_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic load_we,
	input wire logic [AddrW-1:0] load_addr,
	input wire logic [CostW-1:0] load_cost,
	input wire idx_t n,
	input wire cmd_t cmd,
	output sts_t sts
);
	logic signed [PotW-1:0] rowp_q [Dim];
	logic signed [PotW-1:0] colp_q [Dim];
	logic signed [PotW-1:0] slack_q [Dim];
	idx_t match_q [Dim];
	idx_t link_q [Dim];
	logic [Dim-1:0] vis_q;
	idx_t cur_q, next_q, row_now_q;
	logic signed [PotW+1:0] delta_q;
	logic [CostW-1:0] rdata;
	logic [AddrW-1:0] raddr;
	logic pend_s1;
	idx_t pj_s1;
	logic signed [PotW+1:0] red;
	logic signed [PotW-1:0] sl;
	logic [2*IdxW-1:0] prod;

	// cost read: (row_now-1)*n + (j-1), registered
	assign prod = (row_now_q - 1'b1) * n + (cmd.j - 1'b1);
	oas_ram #(.Width(CostW), .Depth(MaxSize*MaxSize)) u_ram (
		.clk, .we(load_we), .waddr(load_addr), .wdata(load_cost),
		.raddr(raddr), .rdata(rdata));
	assign raddr = load_we ? load_addr : prod[AddrW-1:0];

	always_comb begin
		red = $signed({{(PotW+2-CostW){1'b0}}, rdata}) - rowp_q[row_now_q] - colp_q[pj_s1];
		sl = slack_q[pj_s1];
		if (red < sl) sl = sat32(red);
	end

	always_comb begin
		sts.found = next_q != '0;
		sts.cur_free = match_q[next_q] == '0;
		sts.cur_zero = cur_q == '0;
		sts.emit_row = (match_q[cmd.j] == '0) ? '0 : match_q[cmd.j] - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			vis_q <= '0;
		end else begin
			pend_s1 <= (cmd.op == CMD_SCAN) && !vis_q[cmd.j];
			pj_s1 <= cmd.j;
			if (pend_s1) begin
				slack_q[pj_s1] <= sl;
				if (red < slack_q[pj_s1]) link_q[pj_s1] <= cur_q;
				if (sl < delta_q) begin
					delta_q <= sl;
					next_q <= pj_s1;
				end
			end
			case (cmd.op)
				CMD_CLEAR: begin
					for (int k = 0; k < Dim; k++) begin
						rowp_q[k] <= '0; colp_q[k] <= '0;
						match_q[k] <= '0; link_q[k] <= '0;
					end
				end
				CMD_ROW_INIT: begin
					match_q[0] <= cmd.j;
					cur_q <= '0;
					vis_q <= '0;
					for (int k = 0; k < Dim; k++) slack_q[k] <= Inf;
				end
				CMD_VISIT: begin
					vis_q[cur_q] <= 1'b1;
					row_now_q <= (match_q[cur_q] < 1 || match_q[cur_q] > n) ? idx_t'(1)
						: match_q[cur_q];
					delta_q <= {2'b0, Inf};
					next_q <= '0;
				end
				CMD_UPDATE: begin
					if (vis_q[cmd.j]) begin
						rowp_q[match_q[cmd.j]] <= sat32(rowp_q[match_q[cmd.j]] + delta_q);
						colp_q[cmd.j] <= sat32(colp_q[cmd.j] - delta_q);
					end else begin
						slack_q[cmd.j] <= sat32(slack_q[cmd.j] - delta_q);
					end
				end
				CMD_STEP: cur_q <= next_q;
				CMD_AUG: begin
					match_q[cur_q] <= match_q[link_q[cur_q]];
					cur_q <= link_q[cur_q];
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/oas_ctrl.sv =====
`default_nettype none
module oas_ctrl import oas_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	oas_in_if.sink in_ch,
	oas_out_if.source out_ch,
	output logic load_we,
	output logic [AddrW-1:0] load_addr,
	output idx_t n,
	output cmd_t cmd,
	input wire sts_t sts
);
	typedef enum logic [3:0] {
		S_LOAD, S_CLEAR, S_ROW, S_VISIT, S_SCAN, S_DRAIN, S_CHECK, S_UPD, S_STEP,
		S_AUG, S_EMIT
	} state_t;
	typedef logic [2*IdxW-1:0] count_t;
	state_t state_q;
	logic [AddrW-1:0] cnt_q;
	idx_t n_q, i_q, j_q, g_q;
	idx_t s;
	count_t tot;

	assign n = n_q;
	assign load_we = in_ch.valid && in_ch.ready;
	assign load_addr = cnt_q;
	assign in_ch.ready = state_q == S_LOAD;
	assign s = (in_ch.size == 0) ? idx_t'(1) : (in_ch.size > MaxSize ? idx_t'(MaxSize)
		: in_ch.size);

	always_comb begin
		tot = n_q * n_q;
		cmd.j = j_q;
		case (state_q)
			S_CLEAR: cmd.op = CMD_CLEAR;
			S_ROW: begin cmd.op = CMD_ROW_INIT; cmd.j = i_q; end
			S_VISIT: cmd.op = CMD_VISIT;
			S_SCAN: cmd.op = CMD_SCAN;
			S_UPD: cmd.op = CMD_UPDATE;
			S_STEP: cmd.op = CMD_STEP;
			S_AUG: cmd.op = (sts.cur_zero || g_q > n_q) ? CMD_NONE : CMD_AUG;
			S_EMIT: cmd.op = CMD_EMIT;
			default: cmd.op = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q <= '0;
			n_q <= '0;
			i_q <= '0; j_q <= '0; g_q <= '0;
			out_ch.valid <= 1'b0;
			out_ch.column <= '0;
			out_ch.row <= '0;
			out_ch.last <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: if (load_we) begin
					if (cnt_q == 0) n_q <= s;
					if ((cnt_q == 0 ? s * s : tot) == count_t'(cnt_q) + count_t'(1)) begin
						cnt_q <= '0;
						state_q <= S_CLEAR;
					end else cnt_q <= cnt_q + 1'b1;
				end
				S_CLEAR: begin i_q <= idx_t'(1); state_q <= S_ROW; end
				S_ROW: begin g_q <= '0; state_q <= S_VISIT; end
				S_VISIT: begin j_q <= idx_t'(1); state_q <= S_SCAN; end
				S_SCAN: begin
					if (j_q == n_q) state_q <= S_DRAIN;
					else j_q <= j_q + 1'b1;
				end
				S_DRAIN: state_q <= S_CHECK;
				S_CHECK: begin
					j_q <= '0;
					state_q <= sts.found ? S_UPD : S_STEP;
				end
				S_UPD: begin
					if (j_q == n_q) state_q <= S_STEP;
					else j_q <= j_q + 1'b1;
				end
				S_STEP: begin
					if (sts.found && !sts.cur_free && g_q != n_q) begin
						g_q <= g_q + 1'b1;
						state_q <= S_VISIT;
					end else if (sts.found && sts.cur_free) begin
						g_q <= '0;
						state_q <= S_AUG;
					end else if (i_q == n_q) begin
						// no free column reached: row left without augmentation
						j_q <= idx_t'(1);
						state_q <= S_EMIT;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_ROW;
					end
				end
				S_AUG: begin
					if (sts.cur_zero || g_q > n_q) begin
						if (i_q == n_q) begin
							j_q <= idx_t'(1);
							state_q <= S_EMIT;
							out_ch.valid <= 1'b0;
						end else begin
							i_q <= i_q + 1'b1;
							state_q <= S_ROW;
						end
					end else g_q <= g_q + 1'b1;
				end
				S_EMIT: begin
					if (!out_ch.valid) begin
						out_ch.valid <= 1'b1;
						out_ch.column <= 4'(j_q - 1'b1);
						out_ch.row <= sts.emit_row[3:0];
						out_ch.last <= j_q == n_q;
					end else if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						if (j_q == n_q) state_q <= S_LOAD;
						else j_q <= j_q + 1'b1;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/optimal_assignment_solver_core.sv =====
`default_nettype none
// minimum-cost square assignment by kuhn-munkres with potentials. feed n*n cost
// items row-major; size is sampled on the first item of a problem (0 reads as 1,
// above 16 saturates). loading takes one item per cycle. the solve then runs a
// clear step and, per row, a setup step plus up to n+1 search steps (each scans
// one column per cycle for the cost scan and, when a column was found, again for
// the potential update), then an augmentation walk back along the links. one result
// item per column then goes out in column order, with last on the final column.
// input is not taken while solving or emitting.
module optimal_assignment_solver_core import oas_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	oas_in_if.sink in_ch,
	oas_out_if.source out_ch
);
	logic load_we;
	logic [AddrW-1:0] load_addr;
	idx_t n;
	cmd_t cmd;
	sts_t sts;

	// sequencer: loading, search loop, augmentation, emission
	oas_ctrl u_ctrl (.clk, .arst_n, .in_ch, .out_ch, .load_we, .load_addr, .n, .cmd,
		.sts);

	// potentials, slacks, matching and the cost ram
	oas_datapath u_dp (.clk, .arst_n, .load_we, .load_addr, .load_cost(in_ch.cost),
		.n, .cmd, .sts);

	// no item is taken while results are still going out
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input taken during output");
	// nothing follows right after the final result
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.ready && out_ch.last) |=> !out_ch.valid)
		else $error("result after last");
endmodule
`default_nettype wire
